@@ rtl/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared constants and types of the trial-division prime generator.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int MAX_PRIMES = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(MAX_PRIMES);
    localparam int COUNT_W    = $clog2(MAX_PRIMES + 1);
    localparam int RANK_W     = 10;
    localparam int RANK_CFG_W = 11;
    localparam int DIV_CNT_W  = $clog2(VALUE_BITS + 1);

    localparam logic [VALUE_BITS-1:0] PRIME_FIRST  = VALUE_BITS'(2);
    localparam logic [VALUE_BITS-1:0] PRIME_SECOND = VALUE_BITS'(3);
    localparam logic [VALUE_BITS-1:0] CAND_FIRST   = VALUE_BITS'(5);
    localparam logic [VALUE_BITS-1:0] CAND_STEP    = VALUE_BITS'(2);

    localparam logic [RANK_CFG_W-1:0] MAX_RANK_RESET  = RANK_CFG_W'(1024);
    localparam logic [31:0]           MAX_VALUE_RESET = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic CFG_MAX_RANK  = 1'b0;
    localparam logic CFG_MAX_VALUE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CAND,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_PASS,
        ST_FAIL,
        ST_EMIT,
        ST_OUT
    } ptd_state_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } ptd_div_status_t;

endpackage

@@ rtl/prime_trial_division_generator.sv @@
// ----------------------------------------------------------------------------
// prime_trial_division_generator
// Returns the next prime per request, found by trial division over a table.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one request; s_restart=1 resets the table count and
//   the sequence restarts at 2. Each request yields exactly one result on
//   m_valid/m_ready: prime value, zero-based rank and a done flag (value and
//   rank 0 when done). cfg_valid/cfg_ready write max_rank (index 0) and
//   max_value (index 1); writes are always taken, but the user must issue
//   them only while idle, since the block itself does not enforce this.
// Operation:
//   2 and 3 come back without a candidate search. Later primes test each odd
//   candidate against the stored primes from 3 up that lie below candidate/2;
//   each trial is a table read and check, then the bit-serial remainder unit
//   at one dividend bit per cycle.
//   The remainder unit sets the rate; the block serves one request at a time.
// Reset (aresetn low, synchronous): sequence restarts at 2, limits go to
//   1024 and 0xFFFFFFFF. The table is not cleared; only written entries are
//   read. A stalled receiver holds the result register; the next request
//   is taken and worked on, and waits in ST_OUT until the register frees.
// ----------------------------------------------------------------------------
module prime_trial_division_generator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_restart,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ptd_pkg::VALUE_BITS-1:0]    m_prime_value,
    output logic [ptd_pkg::RANK_W-1:0]        m_prime_rank,
    output logic                              m_done_res,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [31:0]                       cfg_data
);
    import ptd_pkg::*;

    ptd_state_t state_reg, state_next;

    logic [RANK_CFG_W-1:0] max_rank_reg;
    logic [VALUE_BITS-1:0] max_value_reg;
    logic [COUNT_W-1:0]    prime_count_reg;
    logic [COUNT_W-1:0]    emitted_count_reg;
    logic [VALUE_BITS-1:0] cand_reg;
    logic                  finished_reg;
    logic [COUNT_W-1:0]    idx_reg;
    logic [VALUE_BITS-1:0] found_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic [RANK_W-1:0]     res_rank_reg;
    logic                  res_done_reg;
    logic                  m_valid_reg;
    logic [VALUE_BITS-1:0] m_value_reg;
    logic [RANK_W-1:0]     m_rank_reg;
    logic                  m_done_reg;

    logic [COUNT_W-1:0]    rank_limit;
    logic                  rank_reached;
    logic                  cand_over;
    logic                  cand_last;
    logic                  idx_end;
    logic                  div_skip;
    logic                  out_free;
    logic                  ram_we;
    logic                  ram_re;
    logic                  div_start;
    logic [VALUE_BITS-1:0] ram_rdata;
    ptd_div_status_t       div_status;

    // max_rank saturates at the table depth
    assign rank_limit   = (max_rank_reg > RANK_CFG_W'(MAX_PRIMES)) ?
                          COUNT_W'(MAX_PRIMES) : COUNT_W'(max_rank_reg);
    assign rank_reached = finished_reg || (emitted_count_reg >= rank_limit);
    assign cand_over    = cand_reg > max_value_reg;
    // no odd candidate above this one fits under the limit
    assign cand_last    = ({1'b0, cand_reg} + {1'b0, CAND_STEP}) > {1'b0, max_value_reg};
    assign idx_end      = idx_reg >= prime_count_reg;
    // divisor reached candidate/2: candidate is prime
    assign div_skip     = ram_rdata >= (cand_reg >> 1);
    assign out_free     = !m_valid_reg || m_ready;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                if (rank_reached) state_next = ST_OUT;
                else if (emitted_count_reg < COUNT_W'(2)) state_next = ST_EMIT;
                else state_next = ST_CAND;
            end
            ST_CAND: begin
                if (cand_over) state_next = ST_OUT;
                else state_next = ST_READ;
            end
            ST_READ: begin
                if (idx_end) state_next = ST_PASS;
                else state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (div_skip) state_next = ST_PASS;
                else state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_status.done) begin
                    if (div_status.rem_zero) state_next = ST_FAIL;
                    else state_next = ST_READ;
                end
            end
            ST_PASS: state_next = ST_EMIT;
            ST_FAIL: begin
                if (cand_last) state_next = ST_OUT;
                else state_next = ST_CAND;
            end
            ST_EMIT: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        s_ready   = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:  s_ready   = 1'b1;
            ST_READ:  ram_re    = !idx_end;
            ST_CHECK: div_start = !div_skip;
            ST_EMIT:  ram_we    = prime_count_reg < COUNT_W'(MAX_PRIMES);
            default: begin
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rank_reg  <= MAX_RANK_RESET;
            max_value_reg <= MAX_VALUE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAX_RANK:  max_rank_reg  <= cfg_data[RANK_CFG_W-1:0];
                CFG_MAX_VALUE: max_value_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_count_reg   <= '0;
            emitted_count_reg <= '0;
            cand_reg          <= CAND_FIRST;
            finished_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_restart) begin
                        prime_count_reg   <= '0;
                        emitted_count_reg <= '0;
                        cand_reg          <= CAND_FIRST;
                        finished_reg      <= 1'b0;
                    end
                end
                ST_SETUP: begin
                    if (rank_reached) finished_reg <= 1'b1;
                end
                ST_CAND: begin
                    if (cand_over) finished_reg <= 1'b1;
                end
                ST_PASS, ST_FAIL: begin
                    if (cand_last) begin
                        finished_reg <= 1'b1;
                        cand_reg     <= max_value_reg;
                    end else begin
                        cand_reg <= cand_reg + CAND_STEP;
                    end
                end
                ST_EMIT: begin
                    if (ram_we) prime_count_reg <= prime_count_reg + COUNT_W'(1);
                    emitted_count_reg <= emitted_count_reg + COUNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_SETUP: begin
                found_reg     <= (emitted_count_reg == '0) ? PRIME_FIRST : PRIME_SECOND;
                res_value_reg <= '0;
                res_rank_reg  <= '0;
                res_done_reg  <= 1'b1;
            end
            ST_CAND: begin
                idx_reg <= COUNT_W'(1);
            end
            ST_DIV: begin
                if (div_status.done) idx_reg <= idx_reg + COUNT_W'(1);
            end
            ST_PASS: begin
                found_reg <= cand_reg;
            end
            ST_EMIT: begin
                res_value_reg <= found_reg;
                res_rank_reg  <= emitted_count_reg[RANK_W-1:0];
                res_done_reg  <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_value_reg <= res_value_reg;
            m_rank_reg  <= res_rank_reg;
            m_done_reg  <= res_done_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_prime_value = m_value_reg;
    assign m_prime_rank  = m_rank_reg;
    assign m_done_res    = m_done_reg;

    ptd_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(MAX_PRIMES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (prime_count_reg[ADDR_W-1:0]),
        .wdata (found_reg),
        .re    (ram_re),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    ptd_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cand_reg),
        .divisor  (ram_rdata),
        .status   (div_status)
    );

    // ---------------- assertions ----------------
    a_counts_match: assert property (@(posedge aclk) disable iff (!aresetn)
        prime_count_reg == emitted_count_reg)
        else $error("table count and emitted count differ");

    a_read_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK |-> idx_reg < prime_count_reg)
        else $error("table read beyond written entries");

    a_cand_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CAND |-> cand_reg[0])
        else $error("even candidate under test");

    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_prime_value == '0 && m_prime_rank == '0)
        else $error("done result carries a value");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> ##(VALUE_BITS + 1) div_status.done)
        else $error("remainder unit latency wrong");

endmodule

@@ rtl/ptd_ram.sv @@
// ----------------------------------------------------------------------------
// ptd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ptd_divider.sv @@
// ----------------------------------------------------------------------------
// ptd_divider
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptd_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [ptd_pkg::VALUE_BITS-1:0]   dividend,
    input  logic [ptd_pkg::VALUE_BITS-1:0]   divisor,
    output ptd_pkg::ptd_div_status_t         status
);
    import ptd_pkg::*;

    logic [VALUE_BITS-1:0] quot_reg;
    logic [VALUE_BITS-1:0] dsr_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  done_reg;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;

    // shift in next dividend bit, subtract when it fits
    assign trial = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= DIV_CNT_W'(VALUE_BITS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
        end else if (cnt_reg != '0) begin
            quot_reg <= {quot_reg[VALUE_BITS-2:0], 1'b0};
            if (!diff[VALUE_BITS]) begin
                rem_reg <= diff[VALUE_BITS-1:0];
            end else begin
                rem_reg <= trial[VALUE_BITS-1:0];
            end
        end
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

@@ dv/ptd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_checker
// Watches the request, result and register channels of the prime generator.
// It predicts each result from its own copy of the prime table and limits,
// and compares every result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ptd_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_restart,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [ptd_pkg::VALUE_BITS-1:0] m_prime_value,
    input  logic [ptd_pkg::RANK_W-1:0]     m_prime_rank,
    input  logic                           m_done_res,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             errors,
    output int                             pending
);
    import ptd_pkg::*;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [RANK_W-1:0]     rank;
        logic                  done;
    } prime_res_t;

    prime_res_t        expected_primes[$];
    longint unsigned   found_tbl[MAX_PRIMES];
    int unsigned       found_cnt;
    int unsigned       sent_cnt;
    longint unsigned   cand_next;
    bit                seq_done;
    logic [RANK_CFG_W-1:0] rank_cfg;
    logic [31:0]           value_cfg;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit survives_division(input longint unsigned cand);
        longint unsigned d;
        for (int unsigned i = 1; i < found_cnt && i < MAX_PRIMES; i++) begin
            d = found_tbl[i];
            if (d >= (cand >> 1))
                break;
            if (d != 0 && (cand % d) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic prime_res_t next_prime(input bit restart);
        prime_res_t      r;
        int unsigned     rank_lim;
        longint unsigned lim, cand, hit, vmax;
        bit              got;
        got  = 0;
        hit  = 0;
        vmax = (64'd1 << VALUE_BITS) - 1;
        rank_lim = (rank_cfg < MAX_PRIMES) ? rank_cfg : MAX_PRIMES;
        lim = (value_cfg < vmax) ? value_cfg : vmax;
        if (restart) begin
            found_cnt = 0;
            sent_cnt  = 0;
            cand_next = 5;
            seq_done  = 0;
        end
        if (!seq_done && sent_cnt >= rank_lim)
            seq_done = 1;
        if (!seq_done) begin
            if (sent_cnt == 0) begin
                hit = 2;
                got = 1;
            end else if (sent_cnt == 1) begin
                hit = 3;
                got = 1;
            end else begin
                cand = cand_next;
                while (!got) begin
                    if (cand > lim) begin
                        seq_done = 1;
                        break;
                    end
                    if (survives_division(cand)) begin
                        hit = cand;
                        got = 1;
                    end
                    // lim - 2 wraps for tiny limits, as intended
                    if (cand > lim - 64'd2) begin
                        cand = lim;
                        seq_done = 1;
                        break;
                    end
                    cand += 2;
                end
                cand_next = cand;
            end
        end
        if (got) begin
            if (found_cnt < MAX_PRIMES) begin
                found_tbl[found_cnt] = hit;
                found_cnt++;
            end
            r.value = hit[VALUE_BITS-1:0];
            r.rank  = sent_cnt[RANK_W-1:0];
            r.done  = 1'b0;
            sent_cnt++;
        end else begin
            seq_done = 1;
            r.value = '0;
            r.rank  = '0;
            r.done  = 1'b1;
        end
        return r;
    endfunction

    initial begin
        errors    = 0;
        pending   = 0;
        found_cnt = 0;
        sent_cnt  = 0;
        cand_next = 5;
        seq_done  = 0;
        rank_cfg  = MAX_RANK_RESET;
        value_cfg = MAX_VALUE_RESET;
    end

    always @(posedge aclk) begin
        prime_res_t e;
        if (!aresetn) begin
            found_cnt = 0;
            sent_cnt  = 0;
            cand_next = 5;
            seq_done  = 0;
            rank_cfg  = MAX_RANK_RESET;
            value_cfg = MAX_VALUE_RESET;
            expected_primes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MAX_RANK)
                    rank_cfg = cfg_data[RANK_CFG_W-1:0];
                else
                    value_cfg = cfg_data;
            end
            if (s_valid && s_ready)
                expected_primes.push_back(next_prime(s_restart));
            if (m_valid && m_ready) begin
                if (expected_primes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%0d",
                                              m_prime_value));
                end else begin
                    e = expected_primes.pop_front();
                    if (m_prime_value !== e.value)
                        report_mismatch($sformatf("value got %0d exp %0d",
                                                  m_prime_value, e.value));
                    if (m_prime_rank !== e.rank)
                        report_mismatch($sformatf("rank got %0d exp %0d",
                                                  m_prime_rank, e.rank));
                    if (m_done_res !== e.done)
                        report_mismatch($sformatf("done got %0b exp %0b",
                                                  m_done_res, e.done));
                end
            end
        end
        pending = expected_primes.size();
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the trial-division prime generator.
// Directed limit cases first, then random restart/next request streams under
// several register settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import ptd_pkg::*;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_valid = 0;
    logic                  s_ready;
    logic                  s_restart = 0;
    logic                  m_valid;
    logic                  m_ready = 0;
    logic [VALUE_BITS-1:0] m_prime_value;
    logic [RANK_W-1:0]     m_prime_rank;
    logic                  m_done_res;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic                  cfg_index = CFG_MAX_RANK;
    logic [31:0]           cfg_data = '0;
    int                    errors;
    int                    pending;

    // idling off in the final stretch; sink_hold forces a long receiver stall
    bit quiet = 0;
    bit sink_hold = 0;
    int req_total = 0;
    int cfg_total = 0;

    always #1 aclk = ~aclk;

    prime_trial_division_generator u_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_restart,
        .m_valid, .m_ready, .m_prime_value, .m_prime_rank, .m_done_res,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    ptd_checker u_chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_restart,
        .m_valid, .m_ready, .m_prime_value, .m_prime_rank, .m_done_res,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors, .pending
    );

    // one request; valid stays up into the next request unless a gap is drawn
    task automatic send_req(input bit restart);
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        req_total++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic stop_reqs();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // register write, issued only with the block idle
    task automatic write_reg(input logic idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cfg_total++;
        @(posedge aclk);
    endtask

    task automatic set_limits(input logic [31:0] rank, input logic [31:0] value);
        drain();
        write_reg(CFG_MAX_RANK, rank);
        write_reg(CFG_MAX_VALUE, value);
    endtask

    // receiver: random stall bursts, or a long hold-off on request
    initial begin
        forever begin
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                sink_hold = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        logic [31:0] rank_v, value_v;
        int          n_phase;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limits: sequence start, with restart mid-run
        send_req(1'b0);
        send_req(1'b0);
        send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);
        send_req(1'b0);
        stop_reqs();
        drain();            // sender pause until everything is back

        // rank limit 2: 2, 3, then done until restarted
        set_limits(2, 32'hFFFF_FFFF);
        repeat (4) send_req(1'b0);
        send_req(1'b1);
        stop_reqs();
        // rank limit 0 answers done on the first request; rank limit 1 gives 2, then done
        set_limits(0, 32'hFFFF_FFFF);
        send_req(1'b1);
        stop_reqs();
        set_limits(1, 32'hFFFF_FFFF);
        send_req(1'b1);
        send_req(1'b0);
        stop_reqs();
        // value limit below 2 and 3: those still come, then done
        set_limits(11'h7FF, 32'h0);
        send_req(1'b1);
        repeat (3) send_req(1'b0);
        stop_reqs();
        // value limit exactly on a prime, and on an odd composite
        set_limits(1024, 5);
        send_req(1'b1);
        repeat (3) send_req(1'b0);
        stop_reqs();
        set_limits(1024, 9);
        send_req(1'b1);
        repeat (4) send_req(1'b0);
        stop_reqs();

        // long receiver stall while requests keep coming
        set_limits(1024, 32'hFFFF_FFFF);
        sink_hold = 1;
        send_req(1'b1);
        repeat (6) send_req(1'b0);
        stop_reqs();

        // random phases with mixed limits
        n_phase = 0;
        while (req_total < 290) begin
            case ($urandom_range(0, 3))
                0: rank_v = $urandom_range(2, 40);
                1: rank_v = 1024;
                2: rank_v = 11'h7FF;
                default: rank_v = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: value_v = $urandom_range(0, 300);
                1: value_v = 32'hFFFF_FFFF;
                2: value_v = $urandom_range(300, 3000);
                default: value_v = $urandom;
            endcase
            set_limits(rank_v, value_v);
            if (req_total > 250)
                quiet = 1;
            send_req(1'b1);
            repeat (30) send_req($urandom_range(0, 15) == 0);
            stop_reqs();
            n_phase++;
        end

        drain();
        repeat (200) @(posedge aclk);
        $display("Covered %0d requests and %0d register writes over %0d random phases,",
                 req_total, cfg_total, n_phase);
        $display("including rank/value limits at their extremes and a long result stall.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #40ms;
        $display("Timeout with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ prime_trial_division_generator.f @@
rtl/ptd_pkg.sv
rtl/ptd_ram.sv
rtl/ptd_divider.sv
rtl/prime_trial_division_generator.sv
dv/ptd_checker.sv
dv/tb.sv
